// ===== sv/bioi_pkg.sv =====
// Shared types and constants for the box intersection-over-union pipeline.
// No dependencies; every other file imports this package.
package bioi_pkg;

    // Field widths of the input beat
    localparam int COORD_W       = 12;
    localparam int SIZE_W        = 11;
    // Right and bottom edges: signed corner plus unsigned size
    localparam int EDGE_W        = COORD_W + 1;
    // Areas and the union
    localparam int AREA_W        = 2 * SIZE_W;
    localparam int UNION_W       = AREA_W + 1;
    localparam int TRIAL_W       = UNION_W + 1;

    // Fixed-point format of the ratio
    localparam int FRACTION_BITS = 16;
    localparam int RATIO_W       = FRACTION_BITS + 1;
    localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // One quotient bit per divider stage, three stages ahead of the divider
    localparam int DIV_STEPS     = RATIO_W;
    localparam int FRONT_STAGES  = 3;
    localparam int PIPE_STAGES   = FRONT_STAGES + DIV_STEPS;

    // Input beat
    typedef struct packed {
        logic signed [COORD_W-1:0] a_left;
        logic signed [COORD_W-1:0] a_top;
        logic        [SIZE_W-1:0]  a_width;
        logic        [SIZE_W-1:0]  a_height;
        logic signed [COORD_W-1:0] b_left;
        logic signed [COORD_W-1:0] b_top;
        logic        [SIZE_W-1:0]  b_width;
        logic        [SIZE_W-1:0]  b_height;
    } t_bioi_in;

    // Output beat
    typedef struct packed {
        logic [RATIO_W-1:0] overlap_ratio;
        logic               empty_union;
    } t_bioi_out;

    // Overlap extents and box sizes after the first stage
    typedef struct packed {
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] a_width;
        logic [SIZE_W-1:0] a_height;
        logic [SIZE_W-1:0] b_width;
        logic [SIZE_W-1:0] b_height;
    } t_bioi_ovl;

    // Divider working set carried from stage to stage
    typedef struct packed {
        logic [UNION_W-1:0] rem;
        logic [UNION_W-1:0] uni;
        logic [RATIO_W-1:0] quo;
        logic               empty;
    } t_bioi_div;

endpackage

// ===== sv/bioi_overlap.sv =====
// Stage one: box edges, separation test and clamped overlap on each axis.
// Depends on bioi_pkg.
module bioi_overlap (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  bioi_pkg::t_bioi_in   i_data,
    output bioi_pkg::t_bioi_ovl  o_data
);
    import bioi_pkg::*;

    logic signed [EDGE_W-1:0] ax, ay, bx, by;
    logic signed [EDGE_W-1:0] ar, ab, br, bb;
    logic signed [EDGE_W-1:0] x_hi, x_lo, y_hi, y_lo;
    logic signed [EDGE_W-1:0] x_span, y_span;
    logic                     apart;
    t_bioi_ovl                n_data, r_data;

    // Sign-extend corners, add zero-extended sizes
    always_comb begin
        ax = {i_data.a_left[COORD_W-1], i_data.a_left};
        ay = {i_data.a_top[COORD_W-1],  i_data.a_top};
        bx = {i_data.b_left[COORD_W-1], i_data.b_left};
        by = {i_data.b_top[COORD_W-1],  i_data.b_top};
        ar = ax + $signed({2'b00, i_data.a_width});
        ab = ay + $signed({2'b00, i_data.a_height});
        br = bx + $signed({2'b00, i_data.b_width});
        bb = by + $signed({2'b00, i_data.b_height});
    end

    // Separated on either axis gives no overlap
    always_comb begin
        apart  = (ax > br) || (ay > bb) || (ar < bx) || (ab < by);
        x_hi   = (ar < br) ? ar : br;
        x_lo   = (ax > bx) ? ax : bx;
        y_hi   = (ab < bb) ? ab : bb;
        y_lo   = (ay > by) ? ay : by;
        x_span = x_hi - x_lo;
        y_span = y_hi - y_lo;
        // not apart: spans lie in 0..min(size), so the low bits are exact
        n_data.cols     = apart ? '0 : x_span[SIZE_W-1:0];
        n_data.rows     = apart ? '0 : y_span[SIZE_W-1:0];
        n_data.a_width  = i_data.a_width;
        n_data.a_height = i_data.a_height;
        n_data.b_width  = i_data.b_width;
        n_data.b_height = i_data.b_height;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== sv/bioi_area.sv =====
// Stages two and three: intersection and box areas, then the union.
// Depends on bioi_pkg; feeds the first divider stage.
module bioi_area (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  bioi_pkg::t_bioi_ovl  i_data,
    output bioi_pkg::t_bioi_div  o_data
);
    import bioi_pkg::*;

    logic [AREA_W-1:0]  r_inter, r_area_a, r_area_b;
    logic [UNION_W-1:0] n_uni;
    t_bioi_div          n_div, r_div;

    // Three 11x11 products side by side
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inter  <= AREA_W'(i_data.cols)    * AREA_W'(i_data.rows);
            r_area_a <= AREA_W'(i_data.a_width) * AREA_W'(i_data.a_height);
            r_area_b <= AREA_W'(i_data.b_width) * AREA_W'(i_data.b_height);
        end
    end

    // Union never goes negative: the intersection is within each area
    always_comb begin
        n_uni       = {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};
        n_div.rem   = {1'b0, r_inter};
        n_div.uni   = n_uni;
        n_div.quo   = '0;
        n_div.empty = (n_uni == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_data = r_div;

endmodule

// ===== sv/bioi_div_step.sv =====
// One restoring-division stage: one quotient bit per register stage.
// Depends on bioi_pkg; the caller supplies the shifted trial remainder.
module bioi_div_step (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [bioi_pkg::TRIAL_W-1:0]    i_trial,
    input  bioi_pkg::t_bioi_div             i_data,
    output bioi_pkg::t_bioi_div             o_data
);
    import bioi_pkg::*;

    logic [TRIAL_W-1:0] divisor, diff;
    logic               ge;
    t_bioi_div          n_data, r_data;

    // Compare and subtract; the kept remainder stays below a nonzero union
    always_comb begin
        divisor      = {1'b0, i_data.uni};
        ge           = (i_trial >= divisor);
        diff         = i_trial - divisor;
        n_data.rem   = ge ? diff[UNION_W-1:0] : i_trial[UNION_W-1:0];
        n_data.uni   = i_data.uni;
        n_data.quo   = {i_data.quo[RATIO_W-2:0], ge};
        n_data.empty = i_data.empty;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== sv/bioi_out_queue.sv =====
// Two-entry output queue (head register plus skid) at the result port.
// Depends on bioi_pkg.
module bioi_out_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bioi_pkg::t_bioi_out  i_data,
    input  logic                 i_ready,
    output logic                 o_valid,
    output bioi_pkg::t_bioi_out  o_data,
    output logic                 o_full
);
    import bioi_pkg::*;

    t_bioi_out r_head, r_skid;
    logic      r_head_valid, r_skid_valid;
    logic      pop;

    assign pop = r_head_valid && i_ready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            r_head_valid <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else if (i_push) begin
            r_head_valid <= 1'b1;
            r_skid_valid <= r_head_valid;
        end
    end

    // Payload moves
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_head <= r_skid_valid ? r_skid : i_data;
            if (r_skid_valid && i_push) begin
                r_skid <= i_data;
            end
        end else if (i_push) begin
            if (r_head_valid) begin
                r_skid <= i_data;
            end else begin
                r_head <= i_data;
            end
        end
    end

    assign o_valid = r_head_valid;
    assign o_data  = r_head;
    assign o_full  = r_skid_valid;

endmodule

// ===== sv/box_intersection_over_union_top.sv =====
// Top level of the box intersection-over-union pipeline.
// Depends on bioi_pkg, bioi_overlap, bioi_area, bioi_div_step, bioi_out_queue.
//
//   channel   direction  valid        ready         payload
//   -------   ---------  ----------   -----------   ----------------------
//   in        input      i_in_valid   o_in_ready    i_in_data  (t_bioi_in)
//   out       output     o_out_valid  i_out_ready   o_out_data (t_bioi_out)
//
// One beat per cycle sustained while the output accepts. Register stages:
// 3 + FRACTION_BITS + 1 (20 by default) plus the output register: edges,
// products, union, then one restoring-divider stage per quotient bit.
// Synchronous active-low reset clears every stage valid bit and the queue.
// The whole pipeline holds only when its last stage and both queue entries
// are full and the output is stalled.
module box_intersection_over_union_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bioi_pkg::t_bioi_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bioi_pkg::t_bioi_out  o_out_data
);
    import bioi_pkg::*;

    logic [PIPE_STAGES-1:0] r_valid, n_valid;
    logic                   en;
    logic                   q_full;
    t_bioi_ovl              ovl;
    t_bioi_div              div_s [DIV_STEPS+1];
    t_bioi_out              result;

    // Pipeline advance: last stage empty, queue has room, or queue drains
    assign en         = !r_valid[PIPE_STAGES-1] || !q_full || i_out_ready;
    assign o_in_ready = en;

    // Valid bits move with the data
    always_comb begin
        n_valid = r_valid;
        if (en) begin
            n_valid = {r_valid[PIPE_STAGES-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    bioi_overlap u_overlap (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (i_in_data),
        .o_data (ovl)
    );

    bioi_area u_area (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (ovl),
        .o_data (div_s[0])
    );

    // Divider chain: the top bit compares the intersection itself,
    // later bits compare the doubled remainder
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [TRIAL_W-1:0] trial;
        if (k == 0) begin : g_first
            assign trial = {1'b0, div_s[k].rem};
        end else begin : g_next
            assign trial = {div_s[k].rem, 1'b0};
        end
        bioi_div_step u_step (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_trial (trial),
            .i_data  (div_s[k]),
            .o_data  (div_s[k+1])
        );
    end

    // Empty union forces the ratio to zero
    always_comb begin
        result.overlap_ratio = div_s[DIV_STEPS].empty ? '0 : div_s[DIV_STEPS].quo;
        result.empty_union   = div_s[DIV_STEPS].empty;
    end

    bioi_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_valid[PIPE_STAGES-1] && en),
        .i_data  (result),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_full  (q_full)
    );

endmodule

// ===== sv/bioi_checker.sv =====
// Port-level checks for box_intersection_over_union_top, bound to the top.
// Depends on bioi_pkg.
module bioi_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  bioi_pkg::t_bioi_in   i_in_data,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  bioi_pkg::t_bioi_out  o_out_data
);
    import bioi_pkg::*;

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // Empty union always comes with a zero ratio
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.empty_union |-> o_out_data.overlap_ratio == '0)
        else $error("empty union with nonzero ratio");

    // Ratio never exceeds one
    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.overlap_ratio <= RATIO_ONE)
        else $error("ratio above one");

    // Reset leaves no result on the port
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind box_intersection_over_union_top bioi_checker u_bioi_checker (.*);

// ===== tb/sv/box_intersection_over_union_top_tb.sv =====
// Self-checking bench for box_intersection_over_union_top.
// It drives box pairs through the in channel and checks each out beat against an IoU predictor.
// Depends on bioi_pkg and the RTL under sv/.
module box_intersection_over_union_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bioi_pkg::*;

    localparam int PAIR_COUNT    = 550;
    localparam int CALM_TAIL     = 60;
    localparam int SETTLE_CYCLES = 40;

    // A queued box pair; drain_first holds it back until the pipe is empty
    typedef struct {
        t_bioi_in beat;
        bit       drain_first;
    } t_pending_pair;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_bioi_in  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_bioi_out out_data;

    t_pending_pair pair_q[$];
    t_bioi_out     iou_expected[$];

    int   sent_count = 0;
    int   recv_count = 0;
    int   err_count  = 0;
    int   gap_left   = 0;
    int   stall_left = 0;
    logic calm_tail  = 1'b0;

    // Driver scratch
    t_pending_pair next_pair;
    logic          next_valid;
    int            sent_next;
    // Monitor scratch
    t_bioi_out     want;
    logic          next_ready;

    box_intersection_over_union_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #4 clk = ~clk;

    // IoU of one pair: exact floor(inter * 2^FRACTION_BITS / union)
    function automatic t_bioi_out predict_iou(t_bioi_in p);
        longint    ax, ay, aw, ah, bx, by, bw, bh;
        longint    a_right, a_bottom, b_right, b_bottom;
        longint    cols, rows, inter, uni, ratio;
        t_bioi_out r;
        ax = longint'($signed(p.a_left));
        ay = longint'($signed(p.a_top));
        aw = longint'(p.a_width);
        ah = longint'(p.a_height);
        bx = longint'($signed(p.b_left));
        by = longint'($signed(p.b_top));
        bw = longint'(p.b_width);
        bh = longint'(p.b_height);
        a_right  = ax + aw;
        a_bottom = ay + ah;
        b_right  = bx + bw;
        b_bottom = by + bh;
        inter = 0;
        // separated boxes leave the intersection at zero; touching edges give zero extent
        if (!(ax > b_right || ay > b_bottom || a_right < bx || a_bottom < by)) begin
            cols  = ((a_right < b_right) ? a_right : b_right) - ((ax > bx) ? ax : bx);
            rows  = ((a_bottom < b_bottom) ? a_bottom : b_bottom) - ((ay > by) ? ay : by);
            inter = cols * rows;
        end
        uni   = aw * ah + bw * bh - inter;
        ratio = 0;
        r.empty_union = 1'b0;
        if (uni == 0) begin
            r.empty_union = 1'b1;
        end else begin
            ratio = (inter << FRACTION_BITS) / uni;
        end
        r.overlap_ratio = ratio[RATIO_W-1:0];
        return r;
    endfunction

    function automatic t_bioi_in make_pair(int al, int at, int aw, int ah,
                                           int bl, int bt, int bw, int bh);
        t_bioi_in p;
        p.a_left   = al[COORD_W-1:0];
        p.a_top    = at[COORD_W-1:0];
        p.a_width  = aw[SIZE_W-1:0];
        p.a_height = ah[SIZE_W-1:0];
        p.b_left   = bl[COORD_W-1:0];
        p.b_top    = bt[COORD_W-1:0];
        p.b_width  = bw[SIZE_W-1:0];
        p.b_height = bh[SIZE_W-1:0];
        return p;
    endfunction

    // Random pair, mostly overlapping geometry so the divider sees real ratios
    function automatic t_bioi_in random_pair();
        int       kind, max_size;
        int       al, at, aw, ah, bl, bt, bw, bh;
        t_bioi_in p;
        kind     = $urandom_range(0, 99);
        max_size = ($urandom_range(0, 9) == 0) ? 2047 : 300;
        al = $urandom_range(0, 4095) - 2048;
        at = $urandom_range(0, 4095) - 2048;
        aw = $urandom_range(0, max_size);
        ah = $urandom_range(0, max_size);
        bw = $urandom_range(0, max_size);
        bh = $urandom_range(0, max_size);
        if (kind < 15) begin
            // every bit of every field free
            p.a_left   = COORD_W'($urandom);
            p.a_top    = COORD_W'($urandom);
            p.a_width  = SIZE_W'($urandom);
            p.a_height = SIZE_W'($urandom);
            p.b_left   = COORD_W'($urandom);
            p.b_top    = COORD_W'($urandom);
            p.b_width  = SIZE_W'($urandom);
            p.b_height = SIZE_W'($urandom);
            return p;
        end else if (kind < 55) begin
            // partial overlap: B corner anywhere from touching left to touching right
            bl = al + $urandom_range(0, aw + bw) - bw;
            bt = at + $urandom_range(0, ah + bh) - bh;
        end else if (kind < 75) begin
            // tiny boxes close together: zero sizes, touching and separation
            aw = $urandom_range(0, 6);
            ah = $urandom_range(0, 6);
            bw = $urandom_range(0, 6);
            bh = $urandom_range(0, 6);
            bl = al + $urandom_range(0, 16) - 8;
            bt = at + $urandom_range(0, 16) - 8;
        end else if (kind < 90) begin
            // B inside A, sometimes identical
            if ($urandom_range(0, 3) == 0) begin
                bl = al;
                bt = at;
                bw = aw;
                bh = ah;
            end else begin
                bl = al + $urandom_range(0, aw);
                bt = at + $urandom_range(0, ah);
                bw = $urandom_range(0, aw - (bl - al));
                bh = $urandom_range(0, ah - (bt - at));
            end
        end else begin
            // edges that only touch on one axis
            bl = $urandom_range(0, 1) ? al + aw : al - bw;
            bt = at + $urandom_range(0, ah + bh) - bh;
            if ($urandom_range(0, 1) == 1) begin
                bt = $urandom_range(0, 1) ? at + ah : at - bh;
                bl = al + $urandom_range(0, aw + bw) - bw;
            end
        end
        return make_pair(al, at, aw, ah, bl, bt, bw, bh);
    endfunction

    task automatic queue_pair(t_bioi_in p, bit drain_first);
        t_pending_pair e;
        e.beat        = p;
        e.drain_first = drain_first;
        pair_q.insert(pair_q.size(), e);
    endtask

    // Driver: one in beat per handshake, random gap bursts between beats
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            sent_next  = sent_count;
            next_valid = in_valid;
            if (in_valid && in_ready) begin
                iou_expected.insert(iou_expected.size(), predict_iou(in_data));
                sent_next  = sent_next + 1;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (pair_q.size() > 0 &&
                             !(pair_q[0].drain_first && sent_next != recv_count)) begin
                    next_pair  = pair_q.pop_front();
                    in_data   <= next_pair.beat;
                    next_valid = 1'b1;
                    // gaps only in alternate stretches of 64 beats, none near the end
                    if (pair_q.size() >= CALM_TAIL && (sent_next / 64) % 2 == 0 &&
                        $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(1, 10);
                    end
                end
            end
            in_valid   <= next_valid;
            sent_count <= sent_next;
            calm_tail  <= (pair_q.size() < CALM_TAIL);
        end
    end

    // Monitor: compare each out beat with the oldest prediction, stall in bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (recv_count >= sent_count) begin
                    $error("out beat with nothing pending: overlap_ratio=%0d empty_union=%0b",
                           out_data.overlap_ratio, out_data.empty_union);
                    err_count = err_count + 1;
                end else begin
                    want = iou_expected.pop_front();
                    if (out_data.overlap_ratio !== want.overlap_ratio) begin
                        $error("overlap_ratio: expected %0d, actual %0d",
                               want.overlap_ratio, out_data.overlap_ratio);
                        err_count = err_count + 1;
                    end
                    if (out_data.empty_union !== want.empty_union) begin
                        $error("empty_union: expected %0b, actual %0b",
                               want.empty_union, out_data.empty_union);
                        err_count = err_count + 1;
                    end
                    recv_count <= recv_count + 1;
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                next_ready = 1'b0;
            end else if (!calm_tail && (recv_count / 80) % 2 == 1 &&
                         $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 9);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            out_ready <= next_ready;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        // directed pairs
        queue_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);                  // empty union
        queue_pair(make_pair(-2048, -2048, 2047, 2047,
                             -2048, -2048, 2047, 2047), 1'b0);                // identical, max size
        queue_pair(make_pair(2047, 2047, 2047, 2047,
                             2047, 2047, 2047, 2047), 1'b0);                  // edges past 12 bits
        queue_pair(make_pair(-2048, -2048, 2047, 2047,
                             2047, 2047, 2047, 2047), 1'b0);                  // far apart
        queue_pair(make_pair(0, 0, 10, 10, 20, 0, 10, 10), 1'b0);             // apart on x
        queue_pair(make_pair(0, 0, 10, 10, 0, 20, 10, 10), 1'b0);             // apart on y
        queue_pair(make_pair(20, 20, 10, 10, 0, 0, 10, 10), 1'b0);            // mirror, apart
        queue_pair(make_pair(0, 0, 10, 10, 10, 0, 10, 10), 1'b0);             // touch on x
        queue_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 10), 1'b0);             // touch on y
        queue_pair(make_pair(0, 0, 10, 10, 10, 10, 10, 10), 1'b0);            // touch at corner
        queue_pair(make_pair(0, 0, 0, 0, -5, -5, 10, 10), 1'b0);              // point inside box
        queue_pair(make_pair(100, 100, 0, 0, -100, -100, 0, 5), 1'b0);        // empty union, apart
        queue_pair(make_pair(7, 7, 0, 0, 7, 7, 0, 0), 1'b1);                  // empty union, same spot
        queue_pair(make_pair(0, 0, 100, 100, 25, 25, 50, 50), 1'b0);          // containment
        queue_pair(make_pair(-10, -10, 30, 30, 0, 0, 30, 30), 1'b0);          // partial overlap
        queue_pair(make_pair(-1024, -1024, 2047, 2047, 0, 0, 1, 1), 1'b0);    // tiny ratio
        queue_pair(make_pair(-1000, 0, 2047, 1, 0, -1000, 1, 2047), 1'b0);    // thin cross
        queue_pair(make_pair(-2048, -2048, 5, 7, -2046, -2047, 9, 3), 1'b0);  // near lower corner
        queue_pair(make_pair(-1, -1, 1, 1, -1, -1, 1, 1), 1'b0);              // unit, ratio one
        queue_pair(make_pair(0, 0, 3, 1, 1, 0, 3, 1), 1'b0);                  // one half
        queue_pair(make_pair(0, 0, 2, 1, 1, 0, 2, 1), 1'b0);                  // one third
        // random pairs, with a couple of full drains along the way
        for (int n = 0; n < PAIR_COUNT - 21; n++) begin
            queue_pair(random_pair(), (n == 180 || n == 390));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pair_q.size() > 0 || in_valid) @(posedge clk);
        while (recv_count != sent_count) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0) begin
            $display("[box_intersection_over_union_top] OK");
        end else begin
            $display("[box_intersection_over_union_top] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("[box_intersection_over_union_top] ERROR");
        $finish;
    end

endmodule
